@@ src/mld_pkg.sv @@
package mld_pkg;

    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_MARKER_VALUE   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_DATA_TYPE_CODE = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_DESC_TYPE_CODE = 2'd2;

    localparam logic [7:0] MARKER_VALUE_RST   = 8'h7C;
    localparam logic [7:0] DATA_TYPE_CODE_RST = 8'h01;
    localparam logic [7:0] DESC_TYPE_CODE_RST = 8'h02;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD      = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

    localparam logic FRAME_DATA = 1'b0;
    localparam logic FRAME_DESC = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_beat;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_data;
        logic       frame_kind;
        logic [7:0] byte_offset;
        logic       frame_last;
    } t_res_beat;

    typedef struct packed {
        logic [CfgIndexWidth-1:0] index;
        logic [7:0]               data;
    } t_cfg_beat;

endpackage

@@ src/mld_chan_if.sv @@
interface mld_chan_if #(
    parameter type t_beat = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/marker_length_xor_deframer.sv @@
// channel   dir   beat type    payload
// i_rx      in    t_rx_beat    rx_byte
// o_res     out   t_res_beat   result_kind, payload_data, frame_kind, byte_offset, frame_last
// i_cfg     in    t_cfg_beat   index (0 marker, 1 data type, 2 desc type), data
//
// One byte per cycle sustained while no result is stalled; each byte is held in the input register,
// and its result, if it has one, is registered into the result register by the combinational state update.
// Reset is synchronous, active low; control and configuration registers return to their defaults, while the
// input byte and result data registers are not reset. A stalled result holds the result register and, once
// the input register is full, holds i_rx.ready low.
// Configuration writes are taken in every cycle.
module marker_length_xor_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mld_chan_if.sink    i_rx,
    mld_chan_if.source  o_res,
    mld_chan_if.sink    i_cfg
);
    import mld_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_CHK  = 2'd3;

    logic [7:0] r_marker_value;
    logic [7:0] r_data_type_code;
    logic [7:0] r_desc_type_code;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic [1:0] r_phase, n_phase;
    logic       r_marker_seen, n_marker_seen;
    logic       r_kind, n_kind;
    logic [7:0] r_len, n_len;
    logic [7:0] r_taken, n_taken;
    logic [7:0] r_check, n_check;

    logic       r_out_valid;
    t_res_beat  r_out;

    logic       advance;
    logic       res_valid;
    t_res_beat  res;
    logic [7:0] taken_inc;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign taken_inc   = r_taken + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_value   <= MARKER_VALUE_RST;
            r_data_type_code <= DATA_TYPE_CODE_RST;
            r_desc_type_code <= DESC_TYPE_CODE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_MARKER_VALUE:   r_marker_value   <= i_cfg.data.data;
                CFG_DATA_TYPE_CODE: r_data_type_code <= i_cfg.data.data;
                CFG_DESC_TYPE_CODE: r_desc_type_code <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_marker_seen = r_marker_seen;
        n_kind        = r_kind;
        n_len         = r_len;
        n_taken       = r_taken;
        n_check       = r_check;
        res_valid     = 1'b0;
        res           = '0;
        case (r_phase)
            PH_LEN: begin
                n_len   = r_in_byte;
                n_taken = '0;
                n_check = '0;
                n_phase = (r_in_byte == 8'd0) ? PH_CHK : PH_PAY;
            end
            PH_PAY: begin
                n_check          = r_check ^ r_in_byte;
                n_taken          = taken_inc;
                if (taken_inc == r_len) begin
                    n_phase = PH_CHK;
                end
                res_valid        = 1'b1;
                res.result_kind  = KIND_PAYLOAD;
                res.payload_data = r_in_byte;
                res.frame_kind   = r_kind;
                res.byte_offset  = r_taken;
            end
            PH_CHK: begin
                res_valid       = 1'b1;
                res.result_kind = (r_in_byte == r_check) ? KIND_GOOD : KIND_BAD;
                res.frame_kind  = r_kind;
                res.frame_last  = 1'b1;
                n_phase         = PH_HUNT;
                n_marker_seen   = 1'b0;
                n_len           = '0;
                n_taken         = '0;
                n_check         = '0;
            end
            default: begin
                if (r_in_byte == r_marker_value) begin
                    n_marker_seen = 1'b1;
                end else if (r_marker_seen) begin
                    if (r_in_byte == r_data_type_code) begin
                        n_kind        = FRAME_DATA;
                        n_marker_seen = 1'b0;
                        n_phase       = PH_LEN;
                    end else if (r_in_byte == r_desc_type_code) begin
                        n_kind        = FRAME_DESC;
                        n_marker_seen = 1'b0;
                        n_phase       = PH_LEN;
                    end else begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_UNKNOWN;
                        res.frame_last  = 1'b1;
                        n_marker_seen   = 1'b0;
                        n_len           = '0;
                        n_taken         = '0;
                        n_check         = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_HUNT;
            r_marker_seen <= 1'b0;
            r_kind        <= FRAME_DATA;
            r_len         <= '0;
            r_taken       <= '0;
            r_check       <= '0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_marker_seen <= n_marker_seen;
                r_kind        <= n_kind;
                r_len         <= n_len;
                r_taken       <= n_taken;
                r_check       <= n_check;
                r_out_valid   <= res_valid;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.data.rx_byte;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    a_chk_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_CHK |=> r_phase == PH_HUNT && !r_marker_seen && r_check == 8'd0)
        else $error("check byte did not return the deframer to hunting");

    a_payload_count_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_taken != r_len)
        else $error("payload phase with all bytes already taken");

    a_hunt_clear_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> r_check == 8'd0 && r_taken == 8'd0)
        else $error("stale checksum or count while hunting");

    a_payload_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_PAY |=> r_out_valid && r_out.result_kind == KIND_PAYLOAD
            && !r_out.frame_last)
        else $error("payload byte lost");

    a_end_result_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind != KIND_PAYLOAD |->
            r_out.frame_last && r_out.payload_data == 8'd0 && r_out.byte_offset == 8'd0)
        else $error("frame end result malformed");

endmodule
